// File: rtl/akvt_pkg.sv
`default_nettype none

package akvt_pkg;

    localparam int NUM_KEYS    = 16;
    localparam int TIME_BITS   = 32;
    localparam int KEY_W       = 4;
    localparam int KEY_IDX_W   = $clog2(NUM_KEYS);
    localparam int POS_W       = 8;
    localparam int TS_W        = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_PRESS_THR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_THR   = 1'd1;

    localparam logic [POS_W-1:0] PRESS_THR_RST = 8'd128;
    localparam logic [POS_W-1:0] END_THR_RST   = 8'd5;

    // classification done at the front, against the thresholds
    typedef struct packed {
        logic in_range;
        logic below_press;
        logic above_press;
        logic below_end;
    } t_class;

    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic [POS_W-1:0]     sample;
        logic [TIME_BITS-1:0] time_stamp;
        t_class               cls;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

`default_nettype wire

// File: rtl/akvt_front.sv
`default_nettype none

module akvt_front (
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [akvt_pkg::KEY_W-1:0]   i_key_index,
    input  wire logic [akvt_pkg::POS_W-1:0]   i_sample,
    input  wire logic [akvt_pkg::TS_W-1:0]    i_timestamp,
    input  wire logic [akvt_pkg::POS_W-1:0]   i_press_thr,
    input  wire logic [akvt_pkg::POS_W-1:0]   i_end_thr,
    input  wire akvt_pkg::t_queue_status      i_q_status,
    output logic                              o_push,
    output akvt_pkg::t_item                   o_item
);

    localparam int CMP_W = akvt_pkg::KEY_W + 1;

    assign o_in_ready = !i_q_status.full;
    assign o_push     = i_in_valid && !i_q_status.full;

    always_comb begin
        o_item.key         = i_key_index;
        o_item.sample      = i_sample;
        o_item.time_stamp  = akvt_pkg::TIME_BITS'(i_timestamp);
        o_item.cls.in_range    = ({1'b0, i_key_index} < CMP_W'(akvt_pkg::NUM_KEYS));
        o_item.cls.below_press = (i_sample < i_press_thr);
        o_item.cls.above_press = (i_sample > i_press_thr);
        o_item.cls.below_end   = (i_sample < i_end_thr);
    end

endmodule

`default_nettype wire

// File: rtl/akvt_queue.sv
`default_nettype none

module akvt_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire akvt_pkg::t_item      i_item,
    input  wire logic                 i_pop,
    output akvt_pkg::t_item           o_item,
    output akvt_pkg::t_queue_status   o_status
);

    akvt_pkg::t_item                 r_mem [akvt_pkg::QUEUE_DEPTH];
    logic [akvt_pkg::QPTR_W-1:0]     r_wr_ptr, n_wr_ptr;
    logic [akvt_pkg::QPTR_W-1:0]     r_rd_ptr, n_rd_ptr;
    logic [akvt_pkg::QCNT_W-1:0]     r_count, n_count;
    logic                            w_do_pop;

    assign o_status.full  = (r_count == akvt_pkg::QCNT_W'(akvt_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_item         = r_mem[r_rd_ptr];
    assign w_do_pop       = i_pop && !o_status.empty;

    always_comb begin
        n_wr_ptr = i_push   ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/akvt_back.sv
`default_nettype none

module akvt_back (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire akvt_pkg::t_item                  i_item,
    input  wire akvt_pkg::t_queue_status          i_q_status,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  wire logic                             i_out_ready,
    output logic [akvt_pkg::KEY_W-1:0]            o_key_out,
    output logic [akvt_pkg::POS_W-1:0]            o_position,
    output logic                                  o_pressed,
    output logic                                  o_press_event,
    output logic                                  o_end_event,
    output logic                                  o_release_event,
    output logic [akvt_pkg::TS_W-1:0]             o_press_time,
    output logic [akvt_pkg::POS_W-1:0]            o_press_position,
    output logic [akvt_pkg::TS_W-1:0]             o_travel_end_time,
    output logic [akvt_pkg::POS_W-1:0]            o_travel_end_position
);

    localparam int TB = akvt_pkg::TIME_BITS;
    localparam int PW = akvt_pkg::POS_W;

    // per-key records, flip-flops, cleared at reset
    logic [PW-1:0] r_pos    [akvt_pkg::NUM_KEYS];
    logic          r_prs    [akvt_pkg::NUM_KEYS];
    logic [TB-1:0] r_st_t   [akvt_pkg::NUM_KEYS];
    logic [PW-1:0] r_st_p   [akvt_pkg::NUM_KEYS];
    logic [TB-1:0] r_end_t  [akvt_pkg::NUM_KEYS];
    logic [PW-1:0] r_end_p  [akvt_pkg::NUM_KEYS];

    logic                            r_out_valid;
    logic [akvt_pkg::KEY_IDX_W-1:0]  w_idx;
    logic                            w_ok;
    logic [PW-1:0]                   w_prev, w_end_mid;
    logic                            w_pev, w_eev, w_rev, w_prs_mid, n_prs;
    logic [TB-1:0]                   n_st_t, n_end_t;
    logic [PW-1:0]                   n_st_p, n_end_p;

    assign o_pop       = !i_q_status.empty && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign w_idx       = i_item.key[akvt_pkg::KEY_IDX_W-1:0];
    assign w_ok        = i_item.cls.in_range;

    always_comb begin
        w_prev    = r_pos[w_idx];
        w_pev     = i_item.cls.below_press && !r_prs[w_idx] && (w_prev > i_item.sample);
        w_end_mid = w_pev ? '0 : r_end_p[w_idx];
        w_eev     = i_item.cls.below_end && (w_end_mid == '0);
        w_prs_mid = r_prs[w_idx] || w_pev;
        w_rev     = w_prs_mid && i_item.cls.above_press;
        n_prs     = w_prs_mid && !w_rev;
        n_st_t    = w_pev ? i_item.time_stamp : r_st_t[w_idx];
        n_st_p    = w_pev ? i_item.sample     : r_st_p[w_idx];
        n_end_t   = w_eev ? i_item.time_stamp : r_end_t[w_idx];
        n_end_p   = w_eev ? i_item.sample     : w_end_mid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < akvt_pkg::NUM_KEYS; k++) begin
                r_pos[k]   <= '0;
                r_prs[k]   <= 1'b0;
                r_st_t[k]  <= '0;
                r_st_p[k]  <= '0;
                r_end_t[k] <= '0;
                r_end_p[k] <= '0;
            end
        end else if (o_pop && w_ok) begin
            r_pos[w_idx]   <= i_item.sample;
            r_prs[w_idx]   <= n_prs;
            r_st_t[w_idx]  <= n_st_t;
            r_st_p[w_idx]  <= n_st_p;
            r_end_t[w_idx] <= n_end_t;
            r_end_p[w_idx] <= n_end_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // out-of-range key reports zeros besides the key itself
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_key_out             <= i_item.key;
            o_position            <= w_ok ? i_item.sample : '0;
            o_pressed             <= w_ok && n_prs;
            o_press_event         <= w_ok && w_pev;
            o_end_event           <= w_ok && w_eev;
            o_release_event       <= w_ok && w_rev;
            o_press_time          <= w_ok ? akvt_pkg::TS_W'(n_st_t) : '0;
            o_press_position      <= w_ok ? n_st_p : '0;
            o_travel_end_time     <= w_ok ? akvt_pkg::TS_W'(n_end_t) : '0;
            o_travel_end_position <= w_ok ? n_end_p : '0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/analog_key_velocity_tracker_top.sv
`default_nettype none

// Analog key velocity tracker.
// Input channel (i_in_valid / o_in_ready) carries one transaction per key
// position sample: key index, 8-bit position (lower is deeper), timestamp.
// Output channel (o_out_valid / i_out_ready) returns one transaction per
// input with the key's updated record and press / end / release flags.
// Thresholds are set through i_cfg_we / i_cfg_addr / i_cfg_wdata while idle;
// the user must keep to this; the block does not enforce it. Index 0 is the
// press threshold, index 1 the travel-end threshold. Samples pass through the
// queue to the output register. Throughput: 1 transaction per cycle while the
// receiver is ready; the per-key update is one read-modify-write of flip-flop
// records, so consecutive samples of the same key need no forwarding.
// A 4-entry queue sits between the classifier and the update stage. When the
// receiver stalls, the output register holds its transaction, the queue
// fills, and o_in_ready drops once 4 transactions wait.
// Reset (synchronous, active low) clears all key records to zero, empties
// the queue, drops o_out_valid and loads thresholds 128 and 5.

module analog_key_velocity_tracker_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration
    input  wire logic                                 i_cfg_we,
    input  wire logic [akvt_pkg::CFG_IDX_W-1:0]       i_cfg_addr,
    input  wire logic [akvt_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // sample input
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic [akvt_pkg::KEY_W-1:0]           i_key_index,
    input  wire logic [akvt_pkg::POS_W-1:0]           i_sample,
    input  wire logic [akvt_pkg::TS_W-1:0]            i_timestamp,
    // record output
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic [akvt_pkg::KEY_W-1:0]                o_key_out,
    output logic [akvt_pkg::POS_W-1:0]                o_position,
    output logic                                      o_pressed,
    output logic                                      o_press_event,
    output logic                                      o_end_event,
    output logic                                      o_release_event,
    output logic [akvt_pkg::TS_W-1:0]                 o_press_time,
    output logic [akvt_pkg::POS_W-1:0]                o_press_position,
    output logic [akvt_pkg::TS_W-1:0]                 o_travel_end_time,
    output logic [akvt_pkg::POS_W-1:0]                o_travel_end_position
);

    // threshold registers
    logic [akvt_pkg::POS_W-1:0] r_press_thr;
    logic [akvt_pkg::POS_W-1:0] r_end_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_thr <= akvt_pkg::PRESS_THR_RST;
            r_end_thr   <= akvt_pkg::END_THR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                akvt_pkg::CFG_PRESS_THR: r_press_thr <= i_cfg_wdata[akvt_pkg::POS_W-1:0];
                akvt_pkg::CFG_END_THR:   r_end_thr   <= i_cfg_wdata[akvt_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    akvt_pkg::t_item         w_push_item;
    akvt_pkg::t_item         w_head_item;
    akvt_pkg::t_queue_status w_q_status;
    logic                    w_push;
    logic                    w_pop;

    // front: accept and classify against thresholds
    akvt_front u_front (
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_key_index (i_key_index),
        .i_sample    (i_sample),
        .i_timestamp (i_timestamp),
        .i_press_thr (r_press_thr),
        .i_end_thr   (r_end_thr),
        .i_q_status  (w_q_status),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    akvt_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_item   (w_push_item),
        .i_pop    (w_pop),
        .o_item   (w_head_item),
        .o_status (w_q_status)
    );

    // back: per-key record update and output register
    akvt_back u_back (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_item                (w_head_item),
        .i_q_status            (w_q_status),
        .o_pop                 (w_pop),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_key_out             (o_key_out),
        .o_position            (o_position),
        .o_pressed             (o_pressed),
        .o_press_event         (o_press_event),
        .o_end_event           (o_end_event),
        .o_release_event       (o_release_event),
        .o_press_time          (o_press_time),
        .o_press_position      (o_press_position),
        .o_travel_end_time     (o_travel_end_time),
        .o_travel_end_position (o_travel_end_position)
    );

    // a press start always leaves the key pressed
    a_press_sets_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_press_event) |-> o_pressed)
        else $error("press event without pressed flag");

    // release clears the flag and never coincides with a press start
    a_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_release_event) |-> (!o_pressed && !o_press_event))
        else $error("release event inconsistent with flags");

    // a recorded travel end lies below the end threshold
    a_end_below_thr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_end_event) |-> (o_travel_end_position < r_end_thr))
        else $error("travel end recorded above end threshold");

    // the queue only fills behind a transaction waiting at the output
    a_full_only_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.full |-> o_out_valid)
        else $error("queue full with no output transaction waiting");

endmodule

`default_nettype wire
